FILE: rtl/sum_pkg.sv
package sum_pkg;

  // Default number of cells in the insertion chain
  localparam int CAPACITY_DEFAULT = 32;

  // One input item
  typedef struct packed {
    logic signed [31:0] element;
    logic               final_item;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [31:0] value;
    logic               run_end;
    logic               overflowed;
  } out_item_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/sum_cell.sv
module sum_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sum_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  element,
  // left neighbor (smaller values)
  input  logic                left_valid,
  input  logic                left_greater,
  input  logic signed [31:0]  left_value,
  // right neighbor (larger values)
  input  logic                right_valid,
  input  logic signed [31:0]  right_value,
  output logic                valid,
  output logic                greater,
  output logic                equal,
  output logic signed [31:0]  value
);

  logic               valid_r;
  logic               valid_nxt;
  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;
  logic               take;

  // Local compares against the broadcast element
  assign greater = valid_r && (value_r > element);
  assign equal   = valid_r && (value_r == element);

  // This slot changes on insert if it holds a larger value or is the first empty one
  assign take = greater || (!valid_r && left_valid);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = right_valid;
      value_nxt = right_value;
    end else if (ctrl.insert && take) begin
      valid_nxt = 1'b1;
      value_nxt = left_greater ? left_value : element;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;

endmodule

FILE: rtl/sorted_unique_merge_unit.sv
// Sorted set union over a stream of signed 32-bit elements. Elements enter one per
// cycle while in_stall is low into a chain of CAPACITY cells that holds the distinct
// values in ascending order; every cell compares against the incoming element at
// once and shifts right to open a slot, so an element that equals a held value is
// dropped, and a new value that finds the chain full is dropped and raises overflowed
// for the run. The item flagged final_item is taken in like any other, then the chain
// shifts its N held values (1 <= N <= CAPACITY) out through the first cell, one result
// per cycle while out_stall is low, with in_stall high meanwhile. The last result
// carries run_end; the chain is empty afterwards and needs no clearing pass after reset.
module sorted_unique_merge_unit #(
  parameter int CAPACITY = sum_pkg::CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sum_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sum_pkg::out_item_t out_item
);

  logic                      cell_valid   [CAPACITY];
  logic                      cell_greater [CAPACITY];
  logic                      cell_equal   [CAPACITY];
  logic signed [31:0]        cell_value   [CAPACITY];
  logic [CAPACITY-1:0]       valid_vec;
  logic [CAPACITY-1:0]       equal_vec;

  sum_pkg::cell_ctrl_t       ctrl;
  logic                      in_accept;
  logic                      dup;
  logic                      full;
  logic                      load_out;
  logic                      last_out;

  logic                      emit_r;
  logic                      emit_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  sum_pkg::out_item_t        out_item_r;

  // Flatten per-cell flags
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = cell_valid[i];
      equal_vec[i] = cell_equal[i];
    end
  end

  assign dup  = |equal_vec;
  assign full = cell_valid[CAPACITY-1];

  assign in_stall  = emit_r;
  assign in_accept = in_valid && !in_stall;

  // Shift out while the output register is free or being taken
  assign load_out = emit_r && (!out_valid_r || !out_stall);
  assign last_out = !cell_valid[1];

  assign ctrl.insert = in_accept && !dup && !full;
  assign ctrl.shift  = load_out;

  // Insertion chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               l_valid;
    logic               l_greater;
    logic signed [31:0] l_value;
    logic               r_valid;
    logic signed [31:0] r_value;

    if (g == 0) begin : g_first
      assign l_valid   = 1'b1;
      assign l_greater = 1'b0;
      assign l_value   = in_item.element;
    end else begin : g_mid
      assign l_valid   = cell_valid[g-1];
      assign l_greater = cell_greater[g-1];
      assign l_value   = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_value = cell_value[g];
    end else begin : g_inner
      assign r_valid = cell_valid[g+1];
      assign r_value = cell_value[g+1];
    end

    sum_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .element      (in_item.element),
      .left_valid   (l_valid),
      .left_greater (l_greater),
      .left_value   (l_value),
      .right_valid  (r_valid),
      .right_value  (r_value),
      .valid        (cell_valid[g]),
      .greater      (cell_greater[g]),
      .equal        (cell_equal[g]),
      .value        (cell_value[g])
    );
  end

  // Run control and overflow flag
  always_comb begin
    emit_nxt      = emit_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      if (full && !dup) begin
        ovf_nxt = 1'b1;
      end
      if (in_item.final_item) begin
        emit_nxt = 1'b1;
      end
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      if (last_out) begin
        emit_nxt = 1'b0;
        ovf_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      emit_r      <= emit_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r.value      <= cell_value[0];
      out_item_r.run_end    <= last_out;
      out_item_r.overflowed <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Held values always form a prefix of the chain
  a_prefix : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
    else $error("valid cells are not a prefix");

  // A run never starts on an empty chain
  a_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> cell_valid[0])
    else $error("emission with empty chain");

  // A final item starts emission
  a_start : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.final_item) |=> emit_r)
    else $error("final item did not start emission");

  // The last result ends the run and clears the chain and overflow
  a_end : assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && last_out) |=> (!emit_r && !ovf_r && !cell_valid[0]))
    else $error("run did not end cleanly");

endmodule
